// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MAME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MAME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/mame_pkg.sv -----
// shared constants, codes, command struct and helpers of the matrix engine
// no dependencies
`default_nettype none

package mame_pkg;

    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 32;
    localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int DRAIN_LEN  = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'b00,
        CMD_LOAD_B  = 2'b01,
        CMD_COMPUTE = 2'b10
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'b00,
        ST_INDEX = 2'b01,
        ST_DIM   = 2'b10
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OP_MODE = 3'd0,
        CFG_A_ROWS  = 3'd1,
        CFG_A_COLS  = 3'd2,
        CFG_B_ROWS  = 3'd3,
        CFG_B_COLS  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] wr_addr;
        logic              err;
        t_status           err_status;
        logic              issue;
        logic              mul;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              first;
        logic              last;
        logic              tail;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_dp_cmd;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
    endfunction

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (d <= DIM_W'(MAX_DIM));
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mame_ctrl.sv -----
// controller: configuration registers, command decode and the i/j/k walk
// depends on mame_pkg
`default_nettype none

module mame_ctrl (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic [1:0]                          i_cmd,
    input  wire logic [3:0]                          i_row_index,
    input  wire logic [3:0]                          i_col_index,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [mame_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [mame_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                                     busy,
    output mame_pkg::t_dp_cmd                        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic                              r_op_mode;
    logic [mame_pkg::DIM_W-1:0]        r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    logic [mame_pkg::IDX_W-1:0]        r_i, r_j, r_k, n_i, n_j, n_k;
    logic [mame_pkg::IDX_W-1:0]        r_nr_m1, r_nc_m1, r_nk_m1;
    logic [mame_pkg::IDX_W-1:0]        n_nr_m1, n_nc_m1, n_nk_m1;
    logic                              r_mul, n_mul;
    logic [0:0]                        r_drain, n_drain;

    logic                              accept, is_load, is_a, oob, good;
    logic [mame_pkg::DIM_W-1:0]        lim_r, lim_c, inner_c;
    logic                              last_k, last_j, last_i;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= 1'b0;
            r_a_rows  <= mame_pkg::DIM_W'(2);
            r_a_cols  <= mame_pkg::DIM_W'(2);
            r_b_rows  <= mame_pkg::DIM_W'(2);
            r_b_cols  <= mame_pkg::DIM_W'(2);
        end else if (i_cfg_wr_en) begin
            case (mame_pkg::t_cfg_idx'(i_cfg_addr))
                mame_pkg::CFG_OP_MODE: r_op_mode <= i_cfg_wdata[0];
                mame_pkg::CFG_A_ROWS:  r_a_rows  <= i_cfg_wdata;
                mame_pkg::CFG_A_COLS:  r_a_cols  <= i_cfg_wdata;
                mame_pkg::CFG_B_ROWS:  r_b_rows  <= i_cfg_wdata;
                mame_pkg::CFG_B_COLS:  r_b_cols  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    // decode of the accepted word
    always_comb begin
        is_a    = (mame_pkg::t_cmd'(i_cmd) == mame_pkg::CMD_LOAD_A);
        is_load = is_a || (mame_pkg::t_cmd'(i_cmd) == mame_pkg::CMD_LOAD_B);
        lim_r   = is_a ? r_a_rows : r_b_rows;
        lim_c   = is_a ? r_a_cols : r_b_cols;
        oob     = (i_row_index >= lim_r) || (i_col_index >= lim_c) ||
                  (i_row_index >= mame_pkg::DIM_W'(mame_pkg::MAX_DIM)) ||
                  (i_col_index >= mame_pkg::DIM_W'(mame_pkg::MAX_DIM));
        if (r_op_mode) begin
            good = (r_a_cols == r_b_rows) && mame_pkg::dim_ok(r_a_rows) &&
                   mame_pkg::dim_ok(r_a_cols) && mame_pkg::dim_ok(r_b_cols);
        end else begin
            good = (r_a_rows == r_b_rows) && (r_a_cols == r_b_cols) &&
                   mame_pkg::dim_ok(r_a_rows) && mame_pkg::dim_ok(r_a_cols);
        end
        inner_c = r_op_mode ? r_a_cols : mame_pkg::DIM_W'(1);
    end

    assign last_k = (r_k == r_nk_m1);
    assign last_j = (r_j == r_nc_m1);
    assign last_i = (r_i == r_nr_m1);

    // walk and state
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_nr_m1 = r_nr_m1;
        n_nc_m1 = r_nc_m1;
        n_nk_m1 = r_nk_m1;
        n_mul   = r_mul;
        n_drain = r_drain;
        case (r_state)
            S_IDLE: begin
                if (accept && (mame_pkg::t_cmd'(i_cmd) == mame_pkg::CMD_COMPUTE) && good) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_mul   = r_op_mode;
                    n_nr_m1 = mame_pkg::IDX_W'(r_a_rows - mame_pkg::DIM_W'(1));
                    n_nc_m1 = mame_pkg::IDX_W'((r_op_mode ? r_b_cols : r_a_cols)
                                               - mame_pkg::DIM_W'(1));
                    n_nk_m1 = mame_pkg::IDX_W'(inner_c - mame_pkg::DIM_W'(1));
                end
            end
            S_RUN: begin
                if (!last_k) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (!last_j) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                        if (last_i) begin
                            n_state = S_DRAIN;
                            n_drain = '0;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (r_drain == 1'(mame_pkg::DRAIN_LEN - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_nr_m1 <= n_nr_m1;
        r_nc_m1 <= n_nc_m1;
        r_nk_m1 <= n_nk_m1;
        r_mul   <= n_mul;
        r_drain <= n_drain;
    end

    // commands to the datapath
    always_comb begin
        o_cmd.wr_a       = accept && is_a && !oob;
        o_cmd.wr_b       = accept && is_load && !is_a && !oob;
        o_cmd.wr_addr    = mame_pkg::addr_of(i_row_index[mame_pkg::IDX_W-1:0],
                                             i_col_index[mame_pkg::IDX_W-1:0]);
        o_cmd.err        = accept && ((is_load && oob) ||
                           ((mame_pkg::t_cmd'(i_cmd) == mame_pkg::CMD_COMPUTE) && !good));
        o_cmd.err_status = is_load ? mame_pkg::ST_INDEX : mame_pkg::ST_DIM;
        o_cmd.issue      = (r_state == S_RUN);
        o_cmd.mul        = r_mul;
        o_cmd.a_addr     = r_mul ? mame_pkg::addr_of(r_i, r_k) : mame_pkg::addr_of(r_i, r_j);
        o_cmd.b_addr     = r_mul ? mame_pkg::addr_of(r_k, r_j) : mame_pkg::addr_of(r_i, r_j);
        o_cmd.first      = (r_k == '0);
        o_cmd.last       = last_k;
        o_cmd.tail       = last_k && last_j && last_i;
        o_cmd.row        = r_i;
        o_cmd.col        = r_j;
    end

endmodule

`default_nettype wire

// ----- hdl/mame_dp.sv -----
// datapath: element stores, read stage, multiply or add, accumulator, result register
// depends on mame_pkg
`default_nettype none

module mame_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mame_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [mame_pkg::ELEM_WIDTH-1:0]    i_wdata,
    output logic                                    o_strobe,
    output logic [1:0]                              o_status,
    output logic [2:0]                              o_row,
    output logic [2:0]                              o_col,
    output logic [mame_pkg::ELEM_WIDTH-1:0]         o_value,
    output logic                                    o_last
);

    localparam int EW = mame_pkg::ELEM_WIDTH;

    typedef struct packed {
        logic                       vld;
        logic                       mul;
        logic                       first;
        logic                       last;
        logic                       tail;
        logic [mame_pkg::IDX_W-1:0] row;
        logic [mame_pkg::IDX_W-1:0] col;
    } t_pipe;

    logic [EW-1:0]                  r_a_mem [mame_pkg::DEPTH];
    logic [EW-1:0]                  r_b_mem [mame_pkg::DEPTH];
    logic [mame_pkg::DEPTH-1:0]     r_a_vld, r_b_vld;

    logic [EW-1:0]                  r_a_rd, r_b_rd;
    logic                           r_a_hit, r_b_hit;
    t_pipe                          r_s1, r_s2, n_s1;
    logic [EW-1:0]                  r_term, n_term, r_acc, n_sum;
    logic [EW-1:0]                  a_val, b_val;
    logic [2*EW-1:0]                prod;

    logic                           r_strobe, r_last;
    logic [1:0]                     r_status;
    logic [2:0]                     r_row, r_col;
    logic [EW-1:0]                  r_value;

    // stores with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a_mem[i_cmd.wr_addr] <= i_wdata;
        end
        r_a_rd <= r_a_mem[i_cmd.a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_b_mem[i_cmd.wr_addr] <= i_wdata;
        end
        r_b_rd <= r_b_mem[i_cmd.b_addr];
    end

    // written flags: an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (i_cmd.wr_a) begin
                r_a_vld[i_cmd.wr_addr] <= 1'b1;
            end
            if (i_cmd.wr_b) begin
                r_b_vld[i_cmd.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hit <= r_a_vld[i_cmd.a_addr];
        r_b_hit <= r_b_vld[i_cmd.b_addr];
    end

    always_comb begin
        n_s1.vld   = i_cmd.issue;
        n_s1.mul   = i_cmd.mul;
        n_s1.first = i_cmd.first;
        n_s1.last  = i_cmd.last;
        n_s1.tail  = i_cmd.tail;
        n_s1.row   = i_cmd.row;
        n_s1.col   = i_cmd.col;
    end

    assign a_val  = r_a_hit ? r_a_rd : '0;
    assign b_val  = r_b_hit ? r_b_rd : '0;
    assign prod   = a_val * b_val;
    assign n_term = r_s1.mul ? prod[EW-1:0] : a_val + b_val;
    assign n_sum  = r_s2.first ? r_term : r_acc + r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        if (r_s2.vld) begin
            r_acc <= n_sum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.err || (r_s2.vld && r_s2.last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.err) begin
            r_status <= i_cmd.err_status;
            r_row    <= '0;
            r_col    <= '0;
            r_value  <= '0;
            r_last   <= 1'b1;
        end else begin
            r_status <= mame_pkg::ST_OK;
            r_row    <= 3'(r_s2.row);
            r_col    <= 3'(r_s2.col);
            r_value  <= n_sum;
            r_last   <= r_s2.tail;
        end
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_row    = r_row;
    assign o_col    = r_col;
    assign o_value  = r_value;
    assign o_last   = r_last;

endmodule

`default_nettype wire

// ----- hdl/matrix_add_multiply_engine_top.sv -----
// top level of the integer matrix add / multiply engine
// depends on mame_pkg, mame_ctrl, mame_dp
//
// channel   direction  handshake               payload
// command   in         start & !busy           i_cmd i_row_index i_col_index i_element_value
// result    out        o_strobe, one cycle     o_status o_out_row o_out_col o_out_value o_last
// config    in         i_cfg_wr_en             i_cfg_addr i_cfg_wdata
//
// a load is written into its store at accept; an index or dimension error shows in the cycle after accept
// a compute holds busy through the multiply-accumulate walk over rows, cols and inner
// (inner is 1 for addition) and then the drain state; each result passes the read, term and result registers
// one read port per store sets the pace of one term per cycle
// reset is synchronous, active low; stores read as zero until written
// the receiver cannot stall, each result is valid for exactly one cycle
`default_nettype none

module matrix_add_multiply_engine_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic [1:0]                         i_cmd,
    input  wire logic [3:0]                         i_row_index,
    input  wire logic [3:0]                         i_col_index,
    input  wire logic signed [31:0]                 i_element_value,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [mame_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [mame_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                    busy,
    output logic                                    o_strobe,
    output logic [1:0]                              o_status,
    output logic [2:0]                              o_out_row,
    output logic [2:0]                              o_out_col,
    output logic signed [31:0]                      o_out_value,
    output logic                                    o_last
);

    mame_pkg::t_dp_cmd                  dp_cmd;
    logic [mame_pkg::ELEM_WIDTH-1:0]    dp_value;

    mame_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .busy        (busy),
        .o_cmd       (dp_cmd)
    );

    mame_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_wdata  (mame_pkg::ELEM_WIDTH'(i_element_value)),
        .o_strobe (o_strobe),
        .o_status (o_status),
        .o_row    (o_out_row),
        .o_col    (o_out_col),
        .o_value  (dp_value),
        .o_last   (o_last)
    );

    assign o_out_value = 32'(signed'(dp_value));

endmodule

`default_nettype wire

// ----- hdl/mame_chk.sv -----
// port-level checker of the matrix engine, bound to the top level
// depends on mame_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mame_chk (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire logic [1:0]             i_cmd,
    input  wire logic                   busy,
    input  wire logic                   o_strobe,
    input  wire logic [1:0]             o_status,
    input  wire logic [2:0]             o_out_row,
    input  wire logic [2:0]             o_out_col,
    input  wire logic signed [31:0]     o_out_value,
    input  wire logic                   o_last
);

    logic err_word;
    logic cmp_acc;

    assign err_word = o_strobe && (o_status != mame_pkg::ST_OK);
    assign cmp_acc  = start && !busy && (i_cmd == mame_pkg::CMD_COMPUTE);

    // error words are single and carry no element
    `MAME_ASSERT_IMP(a_err_blank, i_clk, i_rst_n, err_word, o_last && (o_out_row == 3'd0) && (o_out_col == 3'd0) && (o_out_value == 32'sd0))

    // a compute either starts a walk or answers with a dimension error
    `MAME_ASSERT_NXT(a_cmp_resp, i_clk, i_rst_n, cmp_acc, busy || (o_strobe && o_last && (o_status == mame_pkg::ST_DIM)))

    // the walk ends exactly on its final word
    `MAME_ASSERT_IMP(a_end_last, i_clk, i_rst_n, $fell(busy), o_strobe && o_last && (o_status == mame_pkg::ST_OK))

    // inner words of a walk only appear while busy
    `MAME_ASSERT_IMP(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, busy && (o_status == mame_pkg::ST_OK))

endmodule

bind matrix_add_multiply_engine_top mame_chk u_chk (.*);

`default_nettype wire

// ----- test/tb_matrix_add_multiply_engine_top.sv -----
// self-checking testbench of the matrix add / multiply engine top level
// drives load and compute words, predicts every result word and checks them in order
// depends on mame_pkg and matrix_add_multiply_engine_top
`default_nettype none

module tb_matrix_add_multiply_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'b11;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RAND_ITEMS  = 148;
    localparam int         SETTLE_LEN  = 8;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
    } t_result_word;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            start           = 1'b0;
    logic [1:0]                      i_cmd           = '0;
    logic [3:0]                      i_row_index     = '0;
    logic [3:0]                      i_col_index     = '0;
    logic signed [31:0]              i_element_value = '0;
    logic                            i_cfg_wr_en     = 1'b0;
    logic [mame_pkg::CFG_IDX_W-1:0]  i_cfg_addr      = '0;
    logic [mame_pkg::CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                            busy;
    logic                            o_strobe;
    logic [1:0]                      o_status;
    logic [2:0]                      o_out_row;
    logic [2:0]                      o_out_col;
    logic signed [31:0]              o_out_value;
    logic                            o_last;

    // predictor state
    logic [31:0] a_mem [mame_pkg::DEPTH];
    logic [31:0] b_mem [mame_pkg::DEPTH];
    logic        cfg_mode   = 1'b0;
    logic [3:0]  cfg_a_rows = 4'd2;
    logic [3:0]  cfg_a_cols = 4'd2;
    logic [3:0]  cfg_b_rows = 4'd2;
    logic [3:0]  cfg_b_cols = 4'd2;

    t_cmd_word    cmd_backlog[$];
    t_result_word expected_words[$];
    t_cmd_word    drive_word;
    t_result_word seen_word;
    t_result_word want_word;
    logic         steady = 1'b0;

    int queued_total   = 0;
    int queued_items   = 0;
    int accepted_total = 0;
    int error_count    = 0;
    int checked_words  = 0;
    int load_count     = 0;
    int index_errors   = 0;
    int compute_count  = 0;
    int dim_errors     = 0;
    int unused_count   = 0;
    int setting_count  = 0;
    int cycle_count    = 0;

    matrix_add_multiply_engine_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_cmd           (i_cmd),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .busy            (busy),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_value     (o_out_value),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic dim_legal(input logic [3:0] d);
        return d >= 4'd1 && d <= 4'(mame_pkg::MAX_DIM);
    endfunction

    function automatic t_result_word error_word(input mame_pkg::t_status st);
        t_result_word w;
        w = '0;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    task automatic predict_results(input t_cmd_word w);
        t_result_word r;
        logic [3:0]   nr;
        logic [3:0]   nc;
        logic [31:0]  acc;
        logic         good;
        int           addr;
        case (w.cmd)
            mame_pkg::CMD_LOAD_A, mame_pkg::CMD_LOAD_B: begin
                load_count++;
                nr = (w.cmd == mame_pkg::CMD_LOAD_A) ? cfg_a_rows : cfg_b_rows;
                nc = (w.cmd == mame_pkg::CMD_LOAD_A) ? cfg_a_cols : cfg_b_cols;
                if (w.row >= nr || w.col >= nc || w.row >= mame_pkg::MAX_DIM ||
                    w.col >= mame_pkg::MAX_DIM) begin
                    index_errors++;
                    expected_words.push_back(error_word(mame_pkg::ST_INDEX));
                end else begin
                    addr = int'(w.row) * mame_pkg::MAX_DIM + int'(w.col);
                    if (w.cmd == mame_pkg::CMD_LOAD_A) a_mem[addr] = w.value;
                    else b_mem[addr] = w.value;
                end
            end
            mame_pkg::CMD_COMPUTE: begin
                compute_count++;
                if (!cfg_mode)
                    good = cfg_a_rows == cfg_b_rows && cfg_a_cols == cfg_b_cols &&
                           dim_legal(cfg_a_rows) && dim_legal(cfg_a_cols);
                else
                    good = cfg_a_cols == cfg_b_rows && dim_legal(cfg_a_rows) &&
                           dim_legal(cfg_a_cols) && dim_legal(cfg_b_cols);
                if (!good) begin
                    dim_errors++;
                    expected_words.push_back(error_word(mame_pkg::ST_DIM));
                end else begin
                    nr = cfg_a_rows;
                    nc = cfg_mode ? cfg_b_cols : cfg_a_cols;
                    for (int i = 0; i < int'(nr); i++) begin
                        for (int j = 0; j < int'(nc); j++) begin
                            if (!cfg_mode) begin
                                acc = a_mem[i*mame_pkg::MAX_DIM+j] +
                                      b_mem[i*mame_pkg::MAX_DIM+j];
                            end else begin
                                acc = '0;
                                for (int k = 0; k < int'(cfg_a_cols); k++)
                                    acc += a_mem[i*mame_pkg::MAX_DIM+k] *
                                           b_mem[k*mame_pkg::MAX_DIM+j];
                            end
                            r.status = mame_pkg::ST_OK;
                            r.row = 3'(i);
                            r.col = 3'(j);
                            r.value = acc;
                            r.last = (i + 1 == int'(nr)) && (j + 1 == int'(nc));
                            expected_words.push_back(r);
                        end
                    end
                end
            end
            default: begin
                unused_count++;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_cmd(input logic [1:0] cmd_code, input logic [3:0] row,
                             input logic [3:0] col, input logic [31:0] value);
        t_cmd_word w;
        w.cmd = cmd_code;
        w.row = row;
        w.col = col;
        w.value = value;
        cmd_backlog.push_back(w);
        queued_total++;
        if (cmd_code != CMD_UNUSED) queued_items++;
    endtask

    // wait until every word is accepted, every result word has come back and the engine is idle
    task automatic settle();
        while (accepted_total != queued_total || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input mame_pkg::t_cfg_idx idx, input logic [3:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            mame_pkg::CFG_OP_MODE: cfg_mode   = value[0];
            mame_pkg::CFG_A_ROWS:  cfg_a_rows = value;
            mame_pkg::CFG_A_COLS:  cfg_a_cols = value;
            mame_pkg::CFG_B_ROWS:  cfg_b_rows = value;
            mame_pkg::CFG_B_COLS:  cfg_b_cols = value;
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [3:0] mode, input logic [3:0] ar,
                                 input logic [3:0] ac, input logic [3:0] br,
                                 input logic [3:0] bc);
        write_reg(mame_pkg::CFG_OP_MODE, mode);
        write_reg(mame_pkg::CFG_A_ROWS, ar);
        write_reg(mame_pkg::CFG_A_COLS, ac);
        write_reg(mame_pkg::CFG_B_ROWS, br);
        write_reg(mame_pkg::CFG_B_COLS, bc);
        setting_count++;
    endtask

    function automatic logic [3:0] pick_dim();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 70) return 4'($urandom_range(4, 1));
        if (p < 85) return 4'($urandom_range(8, 5));
        if (p < 92) return 4'd8;
        if (p < 96) return 4'd0;
        return 4'($urandom_range(15, 9));
    endfunction

    function automatic logic [3:0] pick_index(input logic [3:0] dim);
        int unsigned top;
        if (dim != 0 && $urandom_range(99) < 85) begin
            top = (dim > mame_pkg::MAX_DIM) ? mame_pkg::MAX_DIM : int'(dim);
            return 4'($urandom_range(top - 1));
        end
        return 4'($urandom_range(15));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_results(drive_word);
                accepted_total++;
            end
            if (!start || !busy) begin
                if (cmd_backlog.size() == 0 || (!steady && $urandom_range(99) < 24)) begin
                    start <= 1'b0;
                end else begin
                    drive_word = cmd_backlog.pop_front();
                    start           <= 1'b1;
                    i_cmd           <= drive_word.cmd;
                    i_row_index     <= drive_word.row;
                    i_col_index     <= drive_word.col;
                    i_element_value <= drive_word.value;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_word = {o_status, o_out_row, o_out_col, o_out_value, o_last};
            if (expected_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word status %0d row %0d col %0d value %h last %0b",
                              o_status, o_out_row, o_out_col, o_out_value, o_last));
            end else begin
                want_word = expected_words.pop_front();
                checked_words++;
                if (seen_word !== want_word)
                    flag_mismatch($sformatf(
                        "got st %0d r %0d c %0d v %h l %0b, want st %0d r %0d c %0d v %h l %0b",
                        seen_word.status, seen_word.row, seen_word.col, seen_word.value,
                        seen_word.last, want_word.status, want_word.row, want_word.col,
                        want_word.value, want_word.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d result words outstanding", expected_words.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int          phase;
        int          loads;
        logic [3:0]  mode;
        logic [3:0]  ar;
        logic [3:0]  ac;
        logic [3:0]  br;
        logic [3:0]  bc;
        logic [1:0]  c;
        for (int n = 0; n < mame_pkg::DEPTH; n++) begin
            a_mem[n] = '0;
            b_mem[n] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: 2x2 addition with wrapping sums, out-of-range loads and an unused word
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd0, 4'd1, 32'h8000_0000);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd1, 4'd0, 32'hFFFF_FFFF);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd1, 4'd1, 32'h1234_5678);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd0, 4'd0, 32'h0000_0001);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd0, 4'd1, 32'hFFFF_FFFF);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd1, 4'd0, 32'hFFFF_FFFF);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd1, 4'd1, 32'hEDCB_A988);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd2, 4'd0, 32'h5555_5555);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd0, 4'd15, 32'hAAAA_AAAA);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd15, 4'd15, 32'hFFFF_FFFF);
        queue_cmd(CMD_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // 2x2 product
        write_reg(mame_pkg::CFG_OP_MODE, 4'b1111);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // inner dimensions disagree
        write_reg(mame_pkg::CFG_A_COLS, 4'd3);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // zero rows
        write_reg(mame_pkg::CFG_A_COLS, 4'd2);
        write_reg(mame_pkg::CFG_A_ROWS, 4'd0);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // oversized but equal dimensions under addition
        write_setting(4'b0110, 4'd15, 4'd2, 4'd15, 4'd2);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd8, 4'd0, 32'h0000_0007);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // largest product
        write_setting(4'd1, 4'd8, 4'd8, 4'd8, 4'd8);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd7, 4'd7, 32'h7FFF_FFFF);
        queue_cmd(mame_pkg::CMD_LOAD_B, 4'd7, 4'd7, 32'h7FFF_FFFF);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();
        // smallest addition
        write_setting(4'd0, 4'd1, 4'd1, 4'd1, 4'd1);
        queue_cmd(mame_pkg::CMD_LOAD_A, 4'd0, 4'd1, 32'h0000_0001);
        queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        settle();

        // random phases: setting, loads, compute
        phase = 0;
        while (queued_items < 23 + RAND_ITEMS) begin
            steady = (phase >= 4 && phase < 7);
            mode = 4'($urandom_range(15));
            ar = pick_dim();
            ac = pick_dim();
            br = pick_dim();
            bc = pick_dim();
            if ($urandom_range(99) < 75) begin
                if (mode[0]) begin
                    br = ac;
                end else begin
                    br = ar;
                    bc = ac;
                end
            end
            write_setting(mode, ar, ac, br, bc);
            loads = $urandom_range(12, 4);
            for (int n = 0; n < loads; n++) begin
                if ($urandom_range(99) < 5) begin
                    queue_cmd(CMD_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)),
                              $urandom);
                end else begin
                    c = $urandom_range(1) ? mame_pkg::CMD_LOAD_B : mame_pkg::CMD_LOAD_A;
                    if (c == mame_pkg::CMD_LOAD_A)
                        queue_cmd(c, pick_index(ar), pick_index(ac), pick_value());
                    else
                        queue_cmd(c, pick_index(br), pick_index(bc), pick_value());
                end
            end
            queue_cmd(mame_pkg::CMD_COMPUTE, 4'($urandom_range(15)),
                      4'($urandom_range(15)), $urandom);
            if ($urandom_range(99) < 25)
                queue_cmd(mame_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
            settle();
            phase++;
        end
        steady = 1'b0;
        settle();

        $display("ran %0d loads (%0d out of range), %0d computes (%0d bad dimensions), %0d unused",
                 load_count, index_errors, compute_count, dim_errors, unused_count);
        $display("checked %0d result words across %0d register settings",
                 checked_words, setting_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
